@@ src/lwkd_pkg.sv @@
// lwkd_pkg: shared constants and types for longest_window_k_distinct.
// No dependencies; used by every module of the block.
`default_nettype none

package lwkd_pkg;

   localparam int SYM_W             = 8;
   localparam int OUT_W             = 13;
   localparam int DIST_W            = 9;
   localparam int WINDOW_DEPTH_DEF  = 4096;
   localparam int ALPHABET_SIZE_DEF = 256;

   localparam logic [DIST_W-1:0] MAX_DISTINCT_RST = 9'd2;

   // One command to the count unit per cycle
   typedef struct packed {
      logic rd_en;    // read count at addr, data valid next cycle
      logic upd_en;   // write back the count read last time, plus or minus one
      logic dec;      // 1: minus one, 0: plus one
      logic clear;    // drop all counts at end of string
   } cnt_ctrl_type;

endpackage

`default_nettype wire

@@ src/longest_window_k_distinct.sv @@
// Channel | Direction | Ports
// req     | in        | req_valid, req_ready, req_symbol, req_end_of_string
// rsp     | out       | rsp_valid, rsp_ready, rsp_best_length, rsp_window_length,
//         |           | rsp_truncated, rsp_final_res
// csr     | in        | csr_valid, csr_ready, csr_max_distinct
//
// Steps: a byte goes from accept through a store write and count read, a count write
// back and the distinct check to the result register; each byte evicted by the distinct
// limit adds a store read, count read, count write back and recheck, and a full store
// adds the store read, count read and count write back for the forced eviction.
// Eviction count per byte is amortized to at most one. Bytes are taken only in idle.
// Reset: synchronous; counts are dropped through valid bits, so no clearing pass.
// The result register frees the core: a new beat is taken while a result waits,
// and the core stalls at its last step only while the older result is not taken.
// Depends on lwkd_pkg, lwkd_win_mem, lwkd_cnt_unit.
`default_nettype none

module longest_window_k_distinct #(
   parameter int WINDOW_DEPTH  = lwkd_pkg::WINDOW_DEPTH_DEF,
   parameter int ALPHABET_SIZE = lwkd_pkg::ALPHABET_SIZE_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_symbol,
   input  wire logic                        req_end_of_string,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [12:0]                 rsp_best_length,
   output logic      [12:0]                 rsp_window_length,
   output logic                             rsp_truncated,
   output logic                             rsp_final_res,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [8:0]                  csr_max_distinct
);

   localparam int PTR_W      = $clog2(WINDOW_DEPTH);
   localparam int LEN_W      = $clog2(WINDOW_DEPTH + 1);
   localparam int SLOT_W     = $clog2(ALPHABET_SIZE);
   localparam int OUT_W      = lwkd_pkg::OUT_W;
   localparam int DIST_W     = lwkd_pkg::DIST_W;
   localparam int SLOT_RECIP = (65536 + ALPHABET_SIZE - 1) / ALPHABET_SIZE;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_ADD_RD = 7'b0000010,
      S_ADD_WR = 7'b0000100,
      S_CHK    = 7'b0001000,
      S_EV_ST  = 7'b0010000,
      S_EV_CRD = 7'b0100000,
      S_EV_CWR = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [lwkd_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic                       eos_ff, eos_in;
   logic                       pre_ff, pre_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [LEN_W-1:0]           best_ff, best_in;
   logic                       cut_ff, cut_in;
   logic [PTR_W-1:0]           oldest_ff, oldest_in;
   logic [PTR_W-1:0]           newest_ff, newest_in;
   logic [DIST_W-1:0]          max_ff, max_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]           rsp_best_ff, rsp_best_in;
   logic [OUT_W-1:0]           rsp_win_ff, rsp_win_in;
   logic                       rsp_trunc_ff, rsp_trunc_in;
   logic                       rsp_final_ff, rsp_final_in;

   logic                       req_beat;
   logic [LEN_W-1:0]           best_new;
   logic [OUT_W+LEN_W-1:0]     best_ext;
   logic [OUT_W+LEN_W-1:0]     len_ext;
   logic                       win_wr_en;
   logic                       win_rd_en;
   logic [lwkd_pkg::SYM_W-1:0] win_rd_data;
   lwkd_pkg::cnt_ctrl_type     cnt_ctrl;
   logic [SLOT_W-1:0]          cnt_addr;
   logic [DIST_W-1:0]          distinct;
   logic [LEN_W:0]             ptr_sum;

   // Remainder by the alphabet size: reciprocal multiply, exact for 8-bit symbols
   function automatic logic [SLOT_W-1:0] slot_of(input logic [lwkd_pkg::SYM_W-1:0] s);
      logic [24:0] prod;
      logic [16:0] back;
      logic [16:0] rem;
      prod = 25'(s) * 25'(SLOT_RECIP);
      back = 17'(prod[23:16]) * 17'(ALPHABET_SIZE);
      rem  = 17'(s) - back;
      return rem[SLOT_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign best_new = (len_ff > best_ff) ? len_ff : best_ff;
   assign best_ext = {{OUT_W{1'b0}}, best_new};
   assign len_ext  = {{OUT_W{1'b0}}, len_ff};

   always_comb begin
      state_in     = state_ff;
      sym_in       = sym_ff;
      eos_in       = eos_ff;
      pre_in       = pre_ff;
      len_in       = len_ff;
      best_in      = best_ff;
      cut_in       = cut_ff;
      oldest_in    = oldest_ff;
      newest_in    = newest_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_best_in  = rsp_best_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_trunc_in = rsp_trunc_ff;
      rsp_final_in = rsp_final_ff;
      win_wr_en    = 1'b0;
      win_rd_en    = 1'b0;
      cnt_ctrl     = '0;
      cnt_addr     = slot_of(sym_ff);

      if (csr_valid) begin
         max_in = csr_max_distinct;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               sym_in = req_symbol;
               eos_in = req_end_of_string;
               // Store full: drop the oldest byte before this one goes in
               if (len_ff == LEN_W'(WINDOW_DEPTH)) begin
                  pre_in   = 1'b1;
                  cut_in   = 1'b1;
                  state_in = S_EV_ST;
               end else begin
                  state_in = S_ADD_RD;
               end
            end
         end
         S_ADD_RD: begin
            win_wr_en      = 1'b1;
            cnt_ctrl.rd_en = 1'b1;
            newest_in      = ptr_next(newest_ff);
            state_in       = S_ADD_WR;
         end
         S_ADD_WR: begin
            cnt_ctrl.upd_en = 1'b1;
            len_in          = len_ff + LEN_W'(1);
            state_in        = S_CHK;
         end
         S_CHK: begin
            if ((distinct > max_ff) && (len_ff != '0)) begin
               state_in = S_EV_ST;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = best_ext[OUT_W-1:0];
               rsp_win_in   = len_ext[OUT_W-1:0];
               rsp_trunc_in = cut_ff;
               rsp_final_in = eos_ff;
               state_in     = S_IDLE;
               if (eos_ff) begin
                  cnt_ctrl.clear = 1'b1;
                  len_in         = '0;
                  best_in        = '0;
                  cut_in         = 1'b0;
                  oldest_in      = '0;
                  newest_in      = '0;
               end else begin
                  best_in = best_new;
               end
            end
         end
         S_EV_ST: begin
            win_rd_en = 1'b1;
            state_in  = S_EV_CRD;
         end
         S_EV_CRD: begin
            cnt_ctrl.rd_en = 1'b1;
            cnt_addr       = slot_of(win_rd_data);
            state_in       = S_EV_CWR;
         end
         S_EV_CWR: begin
            cnt_ctrl.upd_en = 1'b1;
            cnt_ctrl.dec    = 1'b1;
            oldest_in       = ptr_next(oldest_ff);
            len_in          = len_ff - LEN_W'(1);
            if (pre_ff) begin
               pre_in   = 1'b0;
               state_in = S_ADD_RD;
            end else begin
               state_in = S_CHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         eos_ff       <= 1'b0;
         pre_ff       <= 1'b0;
         len_ff       <= '0;
         best_ff      <= '0;
         cut_ff       <= 1'b0;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         max_ff       <= lwkd_pkg::MAX_DISTINCT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eos_ff       <= eos_in;
         pre_ff       <= pre_in;
         len_ff       <= len_in;
         best_ff      <= best_in;
         cut_ff       <= cut_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: no reset
   always_ff @(posedge clock) begin
      sym_ff       <= sym_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_win_ff   <= rsp_win_in;
      rsp_trunc_ff <= rsp_trunc_in;
      rsp_final_ff <= rsp_final_in;
   end

   lwkd_win_mem #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_win_mem (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (newest_ff),
      .wr_data (sym_ff),
      .rd_en   (win_rd_en),
      .rd_addr (oldest_ff),
      .rd_data (win_rd_data)
   );

   lwkd_cnt_unit #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .CNT_W         (LEN_W)
   ) u_cnt_unit (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (cnt_ctrl),
      .addr     (cnt_addr),
      .distinct (distinct)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_length   = rsp_best_ff;
   assign rsp_window_length = rsp_win_ff;
   assign rsp_truncated     = rsp_trunc_ff;
   assign rsp_final_res     = rsp_final_ff;

   assign ptr_sum = (LEN_W+1)'(oldest_ff) + (LEN_W+1)'(len_ff);

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(WINDOW_DEPTH))
      else $error("window longer than the store");

   a_ptr_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         (ptr_sum == (LEN_W+1)'(newest_ff)) ||
         (ptr_sum == (LEN_W+1)'(newest_ff) + (LEN_W+1)'(WINDOW_DEPTH)))
      else $error("pointers and window length disagree");

   a_best_covers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (best_ff >= len_ff))
      else $error("best length below current window");

endmodule

`default_nettype wire

@@ src/lwkd_win_mem.sv @@
// lwkd_win_mem: window store, one write port and one registered read port.
// Depends on lwkd_pkg for the symbol width.
`default_nettype none

module lwkd_win_mem #(
   parameter int WINDOW_DEPTH = lwkd_pkg::WINDOW_DEPTH_DEF,
   localparam int PTR_W = $clog2(WINDOW_DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [PTR_W-1:0]           wr_addr,
   input  wire logic [lwkd_pkg::SYM_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [PTR_W-1:0]           rd_addr,
   output logic      [lwkd_pkg::SYM_W-1:0] rd_data
);

   logic [lwkd_pkg::SYM_W-1:0] mem [WINDOW_DEPTH];
   logic [lwkd_pkg::SYM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/lwkd_cnt_unit.sv @@
// lwkd_cnt_unit: per-symbol count memory with valid bits, the shared +/-1 unit
// and the distinct-symbol counter. Depends on lwkd_pkg (cnt_ctrl_type, DIST_W).
`default_nettype none

module lwkd_cnt_unit #(
   parameter int ALPHABET_SIZE = lwkd_pkg::ALPHABET_SIZE_DEF,
   parameter int CNT_W         = 13,
   localparam int SLOT_W = $clog2(ALPHABET_SIZE)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lwkd_pkg::cnt_ctrl_type      ctrl,
   input  wire logic [SLOT_W-1:0]           addr,
   output logic      [lwkd_pkg::DIST_W-1:0] distinct
);

   logic [CNT_W-1:0]            mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0]    vld_ff, vld_in;
   logic [CNT_W-1:0]            rd_data_ff;
   logic                        rd_vld_ff;
   logic [SLOT_W-1:0]           addr_ff;
   logic [lwkd_pkg::DIST_W-1:0] distinct_ff, distinct_in;
   logic [CNT_W-1:0]            cur;
   logic [CNT_W-1:0]            upd_val;

   // An entry without its valid bit counts as zero
   assign cur = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      upd_val     = ctrl.dec ? (cur - CNT_W'(1)) : (cur + CNT_W'(1));
      distinct_in = distinct_ff;
      vld_in      = vld_ff;
      if (ctrl.clear) begin
         distinct_in = '0;
         vld_in      = '0;
      end else if (ctrl.upd_en) begin
         vld_in[addr_ff] = 1'b1;
         if (ctrl.dec) begin
            if ((cur == CNT_W'(1)) && (distinct_ff != '0)) begin
               distinct_in = distinct_ff - lwkd_pkg::DIST_W'(1);
            end
         end else if (cur == '0) begin
            distinct_in = distinct_ff + lwkd_pkg::DIST_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.upd_en && !(ctrl.dec && (cur == '0))) begin
         mem[addr_ff] <= upd_val;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[addr];
         rd_vld_ff  <= vld_ff[addr];
         addr_ff    <= addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         distinct_ff <= '0;
      end else begin
         vld_ff      <= vld_in;
         distinct_ff <= distinct_in;
      end
   end

   assign distinct = distinct_ff;

   a_upd_after_rd: assert property (@(posedge clock) disable iff (reset)
      ctrl.upd_en |-> $past(ctrl.rd_en))
      else $error("count update without a read the cycle before");

   a_no_dec_zero: assert property (@(posedge clock) disable iff (reset)
      (ctrl.upd_en && ctrl.dec) |-> (cur != '0))
      else $error("evicting a symbol whose count is zero");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (distinct_ff == '0) && (vld_ff == '0))
      else $error("count clear left state behind");

   a_distinct_max: assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= lwkd_pkg::DIST_W'(ALPHABET_SIZE))
      else $error("distinct counter above alphabet size");

endmodule

`default_nettype wire
